@@ rtl/fmw_pkg.sv @@
// ----------------------------------------------------------------------------
// fmw_pkg: FM operator waveform shared definitions
// Waveform codes, field widths and the log-sine and exponent ROM contents.
// ----------------------------------------------------------------------------
package fmw_pkg;

   // field widths
   localparam int PhaseW  = 10;
   localparam int AttenW  = 10;
   localparam int SampleW = 13;
   localparam int LevelW  = 13;

   // level limits in the log domain
   localparam logic [LevelW-1:0] LevelMax    = 13'h1fff;
   localparam logic [LevelW-1:0] SilentLevel = 13'h1000;

   // waveform select codes
   typedef enum logic [2:0] {
      WAVE_SINE      = 3'd0,
      WAVE_HALF_SINE = 3'd1,
      WAVE_ABS_SINE  = 3'd2,
      WAVE_PULSE     = 3'd3,
      WAVE_ALT_SINE  = 3'd4,
      WAVE_CAMEL     = 3'd5,
      WAVE_SQUARE    = 3'd6,
      WAVE_LOG_SAW   = 3'd7
   } wave_type;

   // quarter-wave log-sine ROM
   localparam logic [11:0] LOG_SINE_ROM [256] = '{
      12'h859, 12'h6c3, 12'h607, 12'h58b, 12'h52e, 12'h4e4, 12'h4a6, 12'h471,
      12'h443, 12'h41a, 12'h3f5, 12'h3d3, 12'h3b5, 12'h398, 12'h37e, 12'h365,
      12'h34e, 12'h339, 12'h324, 12'h311, 12'h2ff, 12'h2ed, 12'h2dc, 12'h2cd,
      12'h2bd, 12'h2af, 12'h2a0, 12'h293, 12'h286, 12'h279, 12'h26d, 12'h261,
      12'h256, 12'h24b, 12'h240, 12'h236, 12'h22c, 12'h222, 12'h218, 12'h20f,
      12'h206, 12'h1fd, 12'h1f5, 12'h1ec, 12'h1e4, 12'h1dc, 12'h1d4, 12'h1cd,
      12'h1c5, 12'h1be, 12'h1b7, 12'h1b0, 12'h1a9, 12'h1a2, 12'h19b, 12'h195,
      12'h18f, 12'h188, 12'h182, 12'h17c, 12'h177, 12'h171, 12'h16b, 12'h166,
      12'h160, 12'h15b, 12'h155, 12'h150, 12'h14b, 12'h146, 12'h141, 12'h13c,
      12'h137, 12'h133, 12'h12e, 12'h129, 12'h125, 12'h121, 12'h11c, 12'h118,
      12'h114, 12'h10f, 12'h10b, 12'h107, 12'h103, 12'h0ff, 12'h0fb, 12'h0f8,
      12'h0f4, 12'h0f0, 12'h0ec, 12'h0e9, 12'h0e5, 12'h0e2, 12'h0de, 12'h0db,
      12'h0d7, 12'h0d4, 12'h0d1, 12'h0cd, 12'h0ca, 12'h0c7, 12'h0c4, 12'h0c1,
      12'h0be, 12'h0bb, 12'h0b8, 12'h0b5, 12'h0b2, 12'h0af, 12'h0ac, 12'h0a9,
      12'h0a7, 12'h0a4, 12'h0a1, 12'h09f, 12'h09c, 12'h099, 12'h097, 12'h094,
      12'h092, 12'h08f, 12'h08d, 12'h08a, 12'h088, 12'h086, 12'h083, 12'h081,
      12'h07f, 12'h07d, 12'h07a, 12'h078, 12'h076, 12'h074, 12'h072, 12'h070,
      12'h06e, 12'h06c, 12'h06a, 12'h068, 12'h066, 12'h064, 12'h062, 12'h060,
      12'h05e, 12'h05c, 12'h05b, 12'h059, 12'h057, 12'h055, 12'h053, 12'h052,
      12'h050, 12'h04e, 12'h04d, 12'h04b, 12'h04a, 12'h048, 12'h046, 12'h045,
      12'h043, 12'h042, 12'h040, 12'h03f, 12'h03e, 12'h03c, 12'h03b, 12'h039,
      12'h038, 12'h037, 12'h035, 12'h034, 12'h033, 12'h031, 12'h030, 12'h02f,
      12'h02e, 12'h02d, 12'h02b, 12'h02a, 12'h029, 12'h028, 12'h027, 12'h026,
      12'h025, 12'h024, 12'h023, 12'h022, 12'h021, 12'h020, 12'h01f, 12'h01e,
      12'h01d, 12'h01c, 12'h01b, 12'h01a, 12'h019, 12'h018, 12'h017, 12'h017,
      12'h016, 12'h015, 12'h014, 12'h014, 12'h013, 12'h012, 12'h011, 12'h011,
      12'h010, 12'h00f, 12'h00f, 12'h00e, 12'h00d, 12'h00d, 12'h00c, 12'h00c,
      12'h00b, 12'h00a, 12'h00a, 12'h009, 12'h009, 12'h008, 12'h008, 12'h007,
      12'h007, 12'h007, 12'h006, 12'h006, 12'h005, 12'h005, 12'h005, 12'h004,
      12'h004, 12'h004, 12'h003, 12'h003, 12'h003, 12'h002, 12'h002, 12'h002,
      12'h002, 12'h001, 12'h001, 12'h001, 12'h001, 12'h001, 12'h001, 12'h001,
      12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000
   };

   // exponent ROM, log level fraction to linear mantissa
   localparam logic [10:0] EXP_ROM [256] = '{
      11'h7fa, 11'h7f5, 11'h7ef, 11'h7ea, 11'h7e4, 11'h7df, 11'h7da, 11'h7d4,
      11'h7cf, 11'h7c9, 11'h7c4, 11'h7bf, 11'h7b9, 11'h7b4, 11'h7ae, 11'h7a9,
      11'h7a4, 11'h79f, 11'h799, 11'h794, 11'h78f, 11'h78a, 11'h784, 11'h77f,
      11'h77a, 11'h775, 11'h770, 11'h76a, 11'h765, 11'h760, 11'h75b, 11'h756,
      11'h751, 11'h74c, 11'h747, 11'h742, 11'h73d, 11'h738, 11'h733, 11'h72e,
      11'h729, 11'h724, 11'h71f, 11'h71a, 11'h715, 11'h710, 11'h70b, 11'h706,
      11'h702, 11'h6fd, 11'h6f8, 11'h6f3, 11'h6ee, 11'h6e9, 11'h6e5, 11'h6e0,
      11'h6db, 11'h6d6, 11'h6d2, 11'h6cd, 11'h6c8, 11'h6c4, 11'h6bf, 11'h6ba,
      11'h6b5, 11'h6b1, 11'h6ac, 11'h6a8, 11'h6a3, 11'h69e, 11'h69a, 11'h695,
      11'h691, 11'h68c, 11'h688, 11'h683, 11'h67f, 11'h67a, 11'h676, 11'h671,
      11'h66d, 11'h668, 11'h664, 11'h65f, 11'h65b, 11'h657, 11'h652, 11'h64e,
      11'h649, 11'h645, 11'h641, 11'h63c, 11'h638, 11'h634, 11'h630, 11'h62b,
      11'h627, 11'h623, 11'h61e, 11'h61a, 11'h616, 11'h612, 11'h60e, 11'h609,
      11'h605, 11'h601, 11'h5fd, 11'h5f9, 11'h5f5, 11'h5f0, 11'h5ec, 11'h5e8,
      11'h5e4, 11'h5e0, 11'h5dc, 11'h5d8, 11'h5d4, 11'h5d0, 11'h5cc, 11'h5c8,
      11'h5c4, 11'h5c0, 11'h5bc, 11'h5b8, 11'h5b4, 11'h5b0, 11'h5ac, 11'h5a8,
      11'h5a4, 11'h5a0, 11'h59c, 11'h599, 11'h595, 11'h591, 11'h58d, 11'h589,
      11'h585, 11'h581, 11'h57e, 11'h57a, 11'h576, 11'h572, 11'h56f, 11'h56b,
      11'h567, 11'h563, 11'h560, 11'h55c, 11'h558, 11'h554, 11'h551, 11'h54d,
      11'h549, 11'h546, 11'h542, 11'h53e, 11'h53b, 11'h537, 11'h534, 11'h530,
      11'h52c, 11'h529, 11'h525, 11'h522, 11'h51e, 11'h51b, 11'h517, 11'h514,
      11'h510, 11'h50c, 11'h509, 11'h506, 11'h502, 11'h4ff, 11'h4fb, 11'h4f8,
      11'h4f4, 11'h4f1, 11'h4ed, 11'h4ea, 11'h4e7, 11'h4e3, 11'h4e0, 11'h4dc,
      11'h4d9, 11'h4d6, 11'h4d2, 11'h4cf, 11'h4cc, 11'h4c8, 11'h4c5, 11'h4c2,
      11'h4be, 11'h4bb, 11'h4b8, 11'h4b5, 11'h4b1, 11'h4ae, 11'h4ab, 11'h4a8,
      11'h4a4, 11'h4a1, 11'h49e, 11'h49b, 11'h498, 11'h494, 11'h491, 11'h48e,
      11'h48b, 11'h488, 11'h485, 11'h482, 11'h47e, 11'h47b, 11'h478, 11'h475,
      11'h472, 11'h46f, 11'h46c, 11'h469, 11'h466, 11'h463, 11'h460, 11'h45d,
      11'h45a, 11'h457, 11'h454, 11'h451, 11'h44e, 11'h44b, 11'h448, 11'h445,
      11'h442, 11'h43f, 11'h43c, 11'h439, 11'h436, 11'h433, 11'h430, 11'h42d,
      11'h42a, 11'h428, 11'h425, 11'h422, 11'h41f, 11'h41c, 11'h419, 11'h416,
      11'h414, 11'h411, 11'h40e, 11'h40b, 11'h408, 11'h406, 11'h403, 11'h400
   };

endpackage

@@ rtl/fmw_shaper.sv @@
// ----------------------------------------------------------------------------
// fmw_shaper: operator waveform datapath
// Phase and waveform to log level, envelope add and clamp, exponent lookup,
// shift and ones'-complement sign.
// ----------------------------------------------------------------------------
module fmw_shaper
   import fmw_pkg::*;
(
   input  logic [PhaseW-1:0]         phase,
   input  logic [AttenW-1:0]         attenuation,
   input  wave_type                  wave_select,
   output logic signed [SampleW-1:0] sample
);

   logic [7:0]        quarter_idx;
   logic [7:0]        double_idx;
   logic [11:0]       quarter_log;
   logic [11:0]       double_log;
   logic [11:0]       pulse_log;
   logic [8:0]        saw_phase;
   logic [LevelW-1:0] log_level;
   logic              negative;
   logic [LevelW:0]   level_sum;
   logic [LevelW-1:0] level;
   logic [10:0]       exp_mant;
   logic [11:0]       magnitude;

   // ROM addresses: mirrored quarter wave and double-speed wave
   assign quarter_idx = phase[7:0] ^ {8{phase[8]}};
   assign double_idx  = {phase[6:0] ^ {7{phase[7]}}, 1'b0};
   assign quarter_log = LOG_SINE_ROM[quarter_idx];
   assign double_log  = LOG_SINE_ROM[double_idx];
   assign pulse_log   = LOG_SINE_ROM[phase[7:0]];
   assign saw_phase   = phase[8:0] ^ {9{phase[9]}};

   // waveform decode to log level and sign
   always_comb begin
      log_level = '0;
      negative  = 1'b0;
      unique case (wave_select)
         WAVE_SINE: begin
            negative  = phase[9];
            log_level = {1'b0, quarter_log};
         end
         WAVE_HALF_SINE: begin
            log_level = phase[9] ? SilentLevel : {1'b0, quarter_log};
         end
         WAVE_ABS_SINE: begin
            log_level = {1'b0, quarter_log};
         end
         WAVE_PULSE: begin
            log_level = phase[8] ? SilentLevel : {1'b0, pulse_log};
         end
         WAVE_ALT_SINE: begin
            negative  = (phase[9:8] == 2'b01);
            log_level = phase[9] ? SilentLevel : {1'b0, double_log};
         end
         WAVE_CAMEL: begin
            log_level = phase[9] ? SilentLevel : {1'b0, double_log};
         end
         WAVE_SQUARE: begin
            negative  = phase[9];
            log_level = '0;
         end
         WAVE_LOG_SAW: begin
            negative  = phase[9];
            log_level = {1'b0, saw_phase, 3'b000};
         end
         default: begin
            log_level = '0;
            negative  = 1'b0;
         end
      endcase
   end

   // envelope add, clamp at the top level
   assign level_sum = {1'b0, log_level} + {1'b0, attenuation, 3'b000};
   assign level     = level_sum[LevelW] ? LevelMax : level_sum[LevelW-1:0];

   // exponent lookup, doubled and shifted by the integer part
   assign exp_mant  = EXP_ROM[level[7:0]];
   assign magnitude = {exp_mant, 1'b0} >> level[12:8];

   // ones' complement sign
   assign sample = negative ? ~{1'b0, magnitude} : {1'b0, magnitude};

endmodule

@@ rtl/fm_operator_waveform.sv @@
// ----------------------------------------------------------------------------
// fm_operator_waveform: FM operator waveform generator
// Turns phase, envelope attenuation and waveform number into one sample.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries phase, attenuation and
//   waveform select; each transaction yields exactly one response
//   transaction (rsp_valid/rsp_ready) carrying the signed 13-bit sample.
//   Path: an accepted request is captured in an input register; the shaper
//   (log-sine ROM, envelope add and clamp, exponent ROM, shift, sign) sits
//   between it and the output register, which drives rsp_valid and
//   rsp_sample.
//   Throughput: one transaction per cycle while the receiver takes results.
//   The single-pass datapath between the two registers sets this figure.
//   Stall: when rsp_ready is low the output register holds its sample; the
//   input register still accepts one more transaction, then req_ready drops
//   until the output drains.
//   Reset (synchronous, active high) empties both registers; no table or
//   state needs initializing, so requests are taken right after reset.
// ----------------------------------------------------------------------------
module fm_operator_waveform
   import fmw_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [PhaseW-1:0]         req_phase,
   input  logic [AttenW-1:0]         req_attenuation,
   input  logic [2:0]                req_wave_select,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [SampleW-1:0] rsp_sample
);

   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic [PhaseW-1:0]         phase_ff;
   logic [AttenW-1:0]         atten_ff;
   wave_type                  wave_ff;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic signed [SampleW-1:0] sample_ff;
   logic signed [SampleW-1:0] sample_in;
   logic                      out_load;
   logic                      in_load;

   // handshake: output register loads when empty or being drained
   assign out_load  = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_load;
   assign in_load   = req_valid && req_ready;

   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (in_load) begin
         phase_ff <= req_phase;
         atten_ff <= req_attenuation;
         wave_ff  <= wave_type'(req_wave_select);
      end
   end

   fmw_shaper u_shaper (
      .phase       (phase_ff),
      .attenuation (atten_ff),
      .wave_select (wave_ff),
      .sample      (sample_in)
   );

   // output payload register
   always_ff @(posedge clock) begin
      if (out_load && in_valid_ff) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = sample_ff;

   // a full input stage moves on whenever the output stage can take it
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_load) |=> out_valid_ff)
      else $error("input stage transaction did not reach the output stage");

   // back-pressure only when both stages hold a transaction
   a_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff))
      else $error("req_ready low with a free stage");

   // reset empties the pipeline
   a_reset: assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !out_valid_ff))
      else $error("pipeline not empty after reset");

endmodule
